FILE: design/mld_pkg.sv
package mld_pkg;

   localparam int MAGIC_BYTES  = 4;
   localparam int LENGTH_BYTES = 4;
   localparam int HDR_BYTES    = MAGIC_BYTES + LENGTH_BYTES;

   localparam int MAGIC_W  = 8 * MAGIC_BYTES;
   localparam int LENGTH_W = 8 * LENGTH_BYTES;
   localparam int HDR_W    = 8 * HDR_BYTES;
   localparam int FILL_W   = $clog2(HDR_BYTES);
   localparam int CSR_W    = 32;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_DISCARD = 1'b1;

   typedef struct packed {
      logic       valid;
      logic       kind;
      logic [7:0] data;
      logic       first;
      logic       last;
   } step_result_type;

endpackage

FILE: design/mld_in_stage.sv
module mld_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       advance,
   output logic       in_valid,
   output logic [7:0] in_byte
);
   import mld_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       take;

   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;
   assign valid_in  = take ? 1'b1 : (advance ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= req_in_byte;
      end
   end

   assign in_valid = valid_ff;
   assign in_byte  = byte_ff;
endmodule

FILE: design/mld_engine.sv
module mld_engine (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [mld_pkg::CSR_W-1:0]        csr_wr_data,
   input  logic                             advance,
   input  logic [7:0]                       in_byte,
   output mld_pkg::step_result_type         result
);
   import mld_pkg::*;

   logic [CSR_W-1:0]    magic_ff;
   logic [HDR_W-1:0]    window_ff;
   logic [HDR_W-1:0]    window_in;
   logic [FILL_W-1:0]   fill_ff;
   logic [FILL_W-1:0]   fill_in;
   logic                in_body_ff;
   logic                in_body_in;
   logic [LENGTH_W-1:0] body_left_ff;
   logic [LENGTH_W-1:0] body_left_in;
   logic                first_pending_ff;
   logic                first_pending_in;
   logic [HDR_W-1:0]    merged;
   logic                full;
   logic                magic_ok;
   logic [LENGTH_W-1:0] hdr_len;

   always_comb begin
      for (int i = 0; i < HDR_BYTES; i++) begin
         if (fill_ff == FILL_W'(i)) begin
            merged[8*i +: 8] = in_byte;
         end else begin
            merged[8*i +: 8] = window_ff[8*i +: 8];
         end
      end
   end

   assign full     = (fill_ff == FILL_W'(HDR_BYTES - 1));
   assign magic_ok = (merged[MAGIC_W-1:0] == magic_ff[MAGIC_W-1:0]);
   assign hdr_len  = merged[HDR_W-1:MAGIC_W];

   always_comb begin
      window_in        = window_ff;
      fill_in          = fill_ff;
      in_body_in       = in_body_ff;
      body_left_in     = body_left_ff;
      first_pending_in = first_pending_ff;
      result           = '0;
      if (advance) begin
         priority if (in_body_ff) begin
            result.valid     = 1'b1;
            result.kind      = KIND_PAYLOAD;
            result.data      = in_byte;
            result.first     = first_pending_ff;
            result.last      = (body_left_ff == LENGTH_W'(1));
            first_pending_in = 1'b0;
            body_left_in     = body_left_ff - LENGTH_W'(1);
            in_body_in       = (body_left_ff != LENGTH_W'(1));
         end else if (!full) begin
            window_in = merged;
            fill_in   = fill_ff + FILL_W'(1);
         end else if (!magic_ok) begin
            result.valid = 1'b1;
            result.kind  = KIND_DISCARD;
            result.data  = merged[7:0];
            window_in    = merged >> 8;
         end else begin
            window_in        = '0;
            fill_in          = '0;
            body_left_in     = hdr_len;
            in_body_in       = (hdr_len != '0);
            first_pending_in = (hdr_len != '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff         <= '0;
         window_ff        <= '0;
         fill_ff          <= '0;
         in_body_ff       <= 1'b0;
         body_left_ff     <= '0;
         first_pending_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            magic_ff <= csr_wr_data;
         end
         window_ff        <= window_in;
         fill_ff          <= fill_in;
         in_body_ff       <= in_body_in;
         body_left_ff     <= body_left_in;
         first_pending_ff <= first_pending_in;
      end
   end
endmodule

FILE: design/mld_out_stage.sv
module mld_out_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  mld_pkg::step_result_type result,
   output logic                     free,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_kind,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_first_of_packet,
   output logic                     rsp_last_of_packet
);
   import mld_pkg::*;

   logic            valid_ff;
   logic            valid_in;
   step_result_type data_ff;

   assign free     = !valid_ff || rsp_ready;
   assign valid_in = load ? result.valid : (rsp_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && result.valid) begin
         data_ff <= result;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_kind            = data_ff.kind;
   assign rsp_out_byte        = data_ff.data;
   assign rsp_first_of_packet = data_ff.first;
   assign rsp_last_of_packet  = data_ff.last;
endmodule

FILE: design/magic_length_deframer_core.sv
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  req_in_byte
// rsp       out        rsp_valid/rsp_ready  rsp_kind, rsp_out_byte, rsp_first_of_packet,
//                                           rsp_last_of_packet
// csr       in         csr_wr_en            csr_wr_data (magic word)
//
// One byte is accepted per cycle while the output is not stalled; a result passes the
// input register and then the output register. The header window, magic compare and
// length counter sit between those two registers and update when a byte advances.
// Reset is synchronous and clears the window, the body counter and the magic word.
// A stalled output holds its transaction; the input stage keeps taking bytes until it
// holds one byte that cannot advance.
module magic_length_deframer_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_in_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_kind,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_first_of_packet,
   output logic                      rsp_last_of_packet,
   input  logic                      csr_wr_en,
   input  logic [mld_pkg::CSR_W-1:0] csr_wr_data
);
   import mld_pkg::*;

   logic            in_valid;
   logic [7:0]      in_byte;
   logic            out_free;
   logic            advance;
   step_result_type result;

   assign advance = in_valid && out_free;

   mld_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .advance     (advance),
      .in_valid    (in_valid),
      .in_byte     (in_byte)
   );

   mld_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .advance     (advance),
      .in_byte     (in_byte),
      .result      (result)
   );

   mld_out_stage u_out_stage (
      .clock               (clock),
      .reset               (reset),
      .load                (advance),
      .result              (result),
      .free                (out_free),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_kind            (rsp_kind),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_first_of_packet (rsp_first_of_packet),
      .rsp_last_of_packet  (rsp_last_of_packet)
   );
endmodule

FILE: design/mld_checker.sv
module mld_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_kind,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_first_of_packet,
   input logic       rsp_last_of_packet
);
   import mld_pkg::*;

   // A stalled result transaction keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_kind)
         && $stable(rsp_first_of_packet) && $stable(rsp_last_of_packet))
      else $error("result transaction changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Discarded bytes never carry packet boundary marks.
   a_discard_marks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_DISCARD) |-> !rsp_first_of_packet && !rsp_last_of_packet)
      else $error("discarded byte marked as packet boundary");

   // Input is never blocked while the output side can drain.
   a_no_bubble: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("input stalled although output can move");
endmodule

bind magic_length_deframer_core mld_checker u_mld_checker (
   .clock               (clock),
   .reset               (reset),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_kind            (rsp_kind),
   .rsp_out_byte        (rsp_out_byte),
   .rsp_first_of_packet (rsp_first_of_packet),
   .rsp_last_of_packet  (rsp_last_of_packet)
);
